@@ rtl/snstdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snstdp_pkg
// Shared types, register codes and constants of the spiking network core.
// ----------------------------------------------------------------------------
package snstdp_pkg;

  // input word modes
  localparam logic [1:0] MODE_SET_AFF = 2'd0;
  localparam logic [1:0] MODE_WR_WGT  = 2'd1;
  localparam logic [1:0] MODE_RD_WGT  = 2'd2;
  localparam logic [1:0] MODE_SUBSTEP = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMBRANE_DECAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNAPSE_DECAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_DECAY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_TICKS = 3'd6;

  // STDP amplitudes in Q0.24 and the weight ceiling in Q2.14
  localparam logic [17:0]        A_DEP     = 18'd176161;
  localparam logic [17:0]        A_POT     = 18'd167772;
  localparam logic signed [21:0] W_CEIL    = 22'sd9830;
  localparam logic [24:0]        TRACE_ONE = 25'd65536;
  localparam logic [24:0]        U24_MAX   = 25'd16777215;

  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         target_neuron;
    logic [4:0]         source_neuron;
    logic signed [15:0] weight_value;
    logic [18:0]        afferent_current;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        spike_mask;
    logic signed [15:0] weight_read;
  } out_word_t;

  typedef struct packed {
    logic [22:0] fire_threshold;
    logic [17:0] drive_gain;
    logic [15:0] membrane_decay;
    logic [15:0] synapse_decay;
    logic [15:0] trace_decay;
    logic [15:0] learn_rate;
    logic [3:0]  refractory_ticks;
  } cfg_t;

  // one neuron's state word
  typedef struct packed {
    logic signed [23:0] mem;
    logic signed [23:0] syn;
    logic [3:0]         refc;
    logic [23:0]        trace;
    logic [18:0]        aff;
  } nrn_t;

  localparam int NRN_W = $bits(nrn_t);

  // saturate to 24 bit signed
  function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
    logic signed [23:0] r;
    if (x > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/spiking_network_stdp_step_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiking_network_stdp_step_core
// Leaky integrate-and-fire network with a recurrent weight store and STDP.
// ----------------------------------------------------------------------------
// Usage: one input word per command on in_valid/in_stall (in_data.mode picks
// set afferent, write weight, read weight or run substep). Every command gives
// exactly one result word on out_valid/out_stall. Configuration registers are
// written over cfg_valid/cfg_ready with cfg_index and cfg_data; the user must
// do so only while idle, as the core does not enforce it. A substep runs the
// STDP pass only when learn_rate is nonzero. The sequencer walks the neuron
// and weight RAMs one entry per step; one word is processed at a time.
// Reset: after rst_n the core clears both RAMs, one weight per cycle;
// in_stall stays high meanwhile. Configuration registers return to their
// defaults at once.
// Stall: a finished result sits in the output register; the next word is
// accepted meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module spiking_network_stdp_step_core
  import snstdp_pkg::*;
#(
  parameter int NEURONS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NIW = $clog2(NEURONS);
  localparam int WDEPTH = NEURONS * NEURONS;
  localparam int WAW = $clog2(WDEPTH);
  localparam logic [NIW-1:0] LAST_N = NIW'(NEURONS - 1);
  localparam logic [WAW-1:0] LAST_W = WAW'(WDEPTH - 1);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_ACC, ST_AFF_WB, ST_WRD,
    ST_N_RD, ST_N_M1, ST_N_M2, ST_N_M3, ST_N_WB,
    ST_P_SCAN, ST_P_RD, ST_P_WB,
    ST_S_SCAN, ST_S_RD, ST_S_M1, ST_S_M2, ST_S_M3, ST_S_M4,
    ST_T_RD, ST_T_WB, ST_DONE
  } state_t;

  cfg_t cfg;

  state_t              state_r, state_nxt;
  logic [WAW-1:0]      clr_r, clr_nxt;
  logic [NIW-1:0]      i_r, i_nxt, j_r, j_nxt;
  logic [NEURONS-1:0]  fired_r, fired_nxt;
  in_word_t            item_r, item_nxt;
  nrn_t                ent_r, ent_nxt;
  logic signed [23:0]  syn_r, syn_nxt;
  logic signed [27:0]  vinf_r, vinf_nxt;
  logic signed [23:0]  v_r, v_nxt;
  logic [23:0]         trace_r, trace_nxt;
  logic [39:0]         prod_r, prod_nxt;
  logic [19:0]         dep_r, dep_nxt, pot_r, pot_nxt;
  logic signed [15:0]  rd_r, rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  // RAM ports
  logic                n_we;
  logic [NIW-1:0]      n_waddr, n_raddr;
  nrn_t                n_wdata;
  logic [NRN_W-1:0]    n_rdata;
  logic                w_we;
  logic [WAW-1:0]      w_waddr, w_raddr;
  logic [15:0]         w_wdata, w_rdata;

  function automatic logic [WAW-1:0] w_addr(input logic [NIW-1:0] row,
                                            input logic [NIW-1:0] col);
    logic [WAW:0] a;
    a = (WAW+1)'(row) * (WAW+1)'(NEURONS) + (WAW+1)'(col);
    return a[WAW-1:0];
  endfunction

  snstdp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  snstdp_ram #(.WIDTH(NRN_W), .DEPTH(NEURONS)) u_nrn_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  snstdp_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // arithmetic datapath
  nrn_t               nrd;
  logic signed [40:0] syn_prod;
  logic signed [23:0] syn_dec;
  logic [40:0]        tr_prod;
  logic signed [24:0] drive;
  logic signed [43:0] g_prod;
  logic signed [28:0] diff;
  logic signed [45:0] m_prod;
  logic signed [30:0] v_sum;
  logic               fire;
  logic signed [24:0] p_sum;
  logic [39:0]        t_prod;
  logic [57:0]        dep_full, pot_full;
  logic signed [15:0] wq;
  logic signed [21:0] w_dn, w_up;
  logic [15:0]        w_dn_c, w_up_c;

  always_comb begin
    nrd      = nrn_t'(n_rdata);
    // synaptic decay, rounded half up
    syn_prod = $signed(nrd.syn) * $signed({1'b0, cfg.synapse_decay}) + 41'sd32768;
    syn_dec  = sat24(32'($signed(syn_prod[40:16])));
    // trace decay
    tr_prod  = 41'(ent_r.trace) * 41'(cfg.trace_decay) + 41'd32768;
    // steady-state potential
    drive    = 25'(syn_r) + $signed({6'b0, ent_r.aff});
    g_prod   = drive * $signed({1'b0, cfg.drive_gain}) + 44'sd32768;
    // exact membrane step towards it
    diff     = 29'(ent_r.mem) - 29'(vinf_r);
    m_prod   = diff * $signed({1'b0, cfg.membrane_decay}) + 46'sd32768;
    v_sum    = 31'(vinf_r) + 31'($signed(m_prod[45:16]));
    fire     = (v_r >= $signed({1'b0, cfg.fire_threshold}));
    // spike propagation
    p_sum    = 25'(nrd.syn) + 25'($signed({w_rdata, 2'b00}));
    // STDP steps
    t_prod   = 40'(nrd.trace) * 40'(cfg.learn_rate);
    dep_full = 58'(prod_r) * 58'(A_DEP) + (58'd1 << 37);
    pot_full = 58'(prod_r) * 58'(A_POT) + (58'd1 << 37);
    wq       = $signed(w_rdata);
    w_dn     = 22'(wq) - $signed({2'b0, dep_r});
    w_up     = 22'(wq) + $signed({2'b0, pot_r});
    w_dn_c   = (w_dn < 22'sd0) ? 16'd0 : w_dn[15:0];
    w_up_c   = (w_up > W_CEIL) ? W_CEIL[15:0] : w_up[15:0];
  end

  // sequencer
  always_comb begin
    logic tgt_ok;
    logic src_ok;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    fired_nxt     = fired_r;
    item_nxt      = item_r;
    ent_nxt       = ent_r;
    syn_nxt       = syn_r;
    vinf_nxt      = vinf_r;
    v_nxt         = v_r;
    trace_nxt     = trace_r;
    prod_nxt      = prod_r;
    dep_nxt       = dep_r;
    pot_nxt       = pot_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    n_we          = 1'b0;
    n_waddr       = i_r;
    n_wdata       = ent_r;
    n_raddr       = i_r;
    w_we          = 1'b0;
    w_waddr       = w_addr(i_r, j_r);
    w_wdata       = 16'd0;
    w_raddr       = w_addr(i_r, j_r);
    tgt_ok = ({1'b0, item_r.target_neuron} < 6'(NEURONS));
    src_ok = ({1'b0, item_r.source_neuron} < 6'(NEURONS));

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // clearing pass over both RAMs
      ST_CLR: begin
        w_we    = 1'b1;
        w_waddr = clr_r;
        if (clr_r < WAW'(NEURONS)) begin
          n_we    = 1'b1;
          n_waddr = clr_r[NIW-1:0];
          n_wdata = '0;
        end
        if (clr_r == LAST_W) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_ACC;
        end
      end

      ST_ACC: begin
        rd_nxt    = 16'sd0;
        state_nxt = ST_DONE;
        case (item_r.mode)
          MODE_SET_AFF: begin
            if (tgt_ok) begin
              n_raddr   = item_r.target_neuron[NIW-1:0];
              state_nxt = ST_AFF_WB;
            end
          end
          MODE_WR_WGT: begin
            if (tgt_ok && src_ok) begin
              w_we    = 1'b1;
              w_waddr = w_addr(item_r.target_neuron[NIW-1:0],
                               item_r.source_neuron[NIW-1:0]);
              w_wdata = item_r.weight_value;
            end
          end
          MODE_RD_WGT: begin
            if (tgt_ok && src_ok) begin
              w_raddr   = w_addr(item_r.target_neuron[NIW-1:0],
                                 item_r.source_neuron[NIW-1:0]);
              state_nxt = ST_WRD;
            end
          end
          default: begin
            i_nxt     = '0;
            fired_nxt = '0;
            state_nxt = ST_N_RD;
          end
        endcase
      end

      ST_AFF_WB: begin
        n_we        = 1'b1;
        n_waddr     = item_r.target_neuron[NIW-1:0];
        n_wdata     = nrd;
        n_wdata.aff = item_r.afferent_current;
        state_nxt   = ST_DONE;
      end

      ST_WRD: begin
        rd_nxt    = wq;
        state_nxt = ST_DONE;
      end

      // neuron walk: decay, integrate, fire
      ST_N_RD: begin
        state_nxt = ST_N_M1;
      end

      ST_N_M1: begin
        ent_nxt   = nrd;
        syn_nxt   = syn_dec;
        state_nxt = ST_N_M2;
      end

      ST_N_M2: begin
        trace_nxt = tr_prod[39:16];
        vinf_nxt  = $signed(g_prod[43:16]);
        state_nxt = ST_N_M3;
      end

      ST_N_M3: begin
        v_nxt     = sat24(32'(v_sum));
        state_nxt = ST_N_WB;
      end

      ST_N_WB: begin
        n_we          = 1'b1;
        n_wdata.syn   = syn_r;
        n_wdata.trace = trace_r;
        n_wdata.aff   = ent_r.aff;
        if (ent_r.refc != 4'd0) begin
          n_wdata.mem  = 24'sd0;
          n_wdata.refc = ent_r.refc - 4'd1;
        end else if (fire) begin
          n_wdata.mem    = 24'sd0;
          n_wdata.refc   = cfg.refractory_ticks;
          fired_nxt[i_r] = 1'b1;
        end else begin
          n_wdata.mem  = v_r;
          n_wdata.refc = 4'd0;
        end
        if (i_r == LAST_N) begin
          j_nxt     = '0;
          state_nxt = ST_P_SCAN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_N_RD;
        end
      end

      // propagation: add each firing neuron's column
      ST_P_SCAN: begin
        if (fired_r[j_r]) begin
          i_nxt     = '0;
          state_nxt = ST_P_RD;
        end else if (j_r == LAST_N) begin
          j_nxt     = '0;
          i_nxt     = '0;
          state_nxt = (cfg.learn_rate != 16'd0) ? ST_S_SCAN : ST_T_RD;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      ST_P_RD: begin
        state_nxt = ST_P_WB;
      end

      ST_P_WB: begin
        n_we        = 1'b1;
        n_wdata     = nrd;
        n_wdata.syn = sat24(32'(p_sum));
        if (i_r != LAST_N) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_P_RD;
        end else if (j_r == LAST_N) begin
          j_nxt     = '0;
          i_nxt     = '0;
          state_nxt = (cfg.learn_rate != 16'd0) ? ST_S_SCAN : ST_T_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_P_SCAN;
        end
      end

      // STDP over each firing neuron's row and column
      ST_S_SCAN: begin
        if (fired_r[j_r]) begin
          i_nxt     = '0;
          state_nxt = ST_S_RD;
        end else if (j_r == LAST_N) begin
          i_nxt     = '0;
          state_nxt = ST_T_RD;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      ST_S_RD: begin
        if (i_r != j_r) begin
          state_nxt = ST_S_M1;
        end else if (i_r != LAST_N) begin
          i_nxt = i_r + 1'b1;
        end else if (j_r == LAST_N) begin
          i_nxt     = '0;
          state_nxt = ST_T_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_S_SCAN;
        end
      end

      ST_S_M1: begin
        prod_nxt  = t_prod;
        state_nxt = ST_S_M2;
      end

      ST_S_M2: begin
        dep_nxt   = dep_full[57:38];
        w_raddr   = w_addr(i_r, j_r);
        state_nxt = ST_S_M3;
      end

      // depress the incoming weight, fetch the outgoing one
      ST_S_M3: begin
        pot_nxt = pot_full[57:38];
        if (wq > 16'sd0) begin
          w_we    = 1'b1;
          w_waddr = w_addr(i_r, j_r);
          w_wdata = w_dn_c;
        end
        w_raddr   = w_addr(j_r, i_r);
        state_nxt = ST_S_M4;
      end

      // potentiate the outgoing weight
      ST_S_M4: begin
        if (wq > 16'sd0) begin
          w_we    = 1'b1;
          w_waddr = w_addr(j_r, i_r);
          w_wdata = w_up_c;
        end
        if (i_r != LAST_N) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_S_RD;
        end else if (j_r == LAST_N) begin
          i_nxt     = '0;
          state_nxt = ST_T_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_S_SCAN;
        end
      end

      // trace bump of neurons that fired
      ST_T_RD: begin
        if (fired_r[i_r]) begin
          state_nxt = ST_T_WB;
        end else if (i_r == LAST_N) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      ST_T_WB: begin
        n_we          = 1'b1;
        n_wdata       = nrd;
        n_wdata.trace = ((25'(nrd.trace) + TRACE_ONE) > U24_MAX) ?
                        U24_MAX[23:0] : (nrd.trace + TRACE_ONE[23:0]);
        if (i_r == LAST_N) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_T_RD;
        end
      end

      // hand the result word to the output register
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.spike_mask  = (item_r.mode == MODE_SUBSTEP) ? 32'(fired_r) : 32'd0;
          out_data_nxt.weight_read = (item_r.mode == MODE_RD_WGT) ? rd_r : 16'sd0;
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    fired_r    <= fired_nxt;
    item_r     <= item_nxt;
    ent_r      <= ent_nxt;
    syn_r      <= syn_nxt;
    vinf_r     <= vinf_nxt;
    v_r        <= v_nxt;
    trace_r    <= trace_nxt;
    prod_r     <= prod_nxt;
    dep_r      <= dep_nxt;
    pot_r      <= pot_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/snstdp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snstdp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module snstdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/snstdp_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snstdp_cfg_regs
// Configuration register bank, written through the cfg word channel.
// ----------------------------------------------------------------------------
module snstdp_cfg_regs
  import snstdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fire_threshold   <= 23'd65536;
      cfg_r.drive_gain       <= 18'd65536;
      cfg_r.membrane_decay   <= 16'd58982;
      cfg_r.synapse_decay    <= 16'd55705;
      cfg_r.trace_decay      <= 16'd58982;
      cfg_r.learn_rate       <= 16'd0;
      cfg_r.refractory_ticks <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRE_THRESHOLD:   cfg_r.fire_threshold   <= cfg_data[22:0];
        CFG_DRIVE_GAIN:       cfg_r.drive_gain       <= cfg_data[17:0];
        CFG_MEMBRANE_DECAY:   cfg_r.membrane_decay   <= cfg_data[15:0];
        CFG_SYNAPSE_DECAY:    cfg_r.synapse_decay    <= cfg_data[15:0];
        CFG_TRACE_DECAY:      cfg_r.trace_decay      <= cfg_data[15:0];
        CFG_LEARN_RATE:       cfg_r.learn_rate       <= cfg_data[15:0];
        CFG_REFRACTORY_TICKS: cfg_r.refractory_ticks <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule
